/* sv/sfap_pkg.sv */
// Shared types and constants for the sync frame attitude parser.
`timescale 1ns / 1ps
`default_nettype none

package sfap_pkg;

  typedef logic [7:0]         byte_t;
  typedef logic [3:0]         pos_t;
  typedef logic [15:0]        angle_u_t;
  typedef logic signed [15:0] angle_s_t;

  // Frame layout: AA 55 ID CMD LEN yaw(2) pitch(2) roll(2) checksum.
  localparam byte_t HdrFirst   = 8'hAA;
  localparam byte_t HdrSecond  = 8'h55;
  localparam pos_t  AfterHdr   = 4'd2;
  localparam pos_t  SumFirst   = 4'd2;
  localparam pos_t  PayloadPos = 4'd5;
  localparam pos_t  PayloadEnd = 4'd10;
  localparam pos_t  CheckPos   = 4'd11;
  localparam pos_t  FrameStart = 4'd0;
  localparam int    PayloadLen = 6;

  // Status of the byte at the head of the tracker.
  typedef struct packed {
    logic complete;  // this byte closes a frame
    logic sum_ok;    // running checksum equals this byte
  } trk_status_t;

endpackage

`default_nettype wire

/* sv/sfap_if.sv */
// Valid/ready channel interfaces for received bytes and frame results.
`timescale 1ns / 1ps
`default_nettype none

interface sfap_in_if;
  import sfap_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfap_out_if;
  import sfap_pkg::*;

  logic     valid;
  logic     ready;
  logic     frame_ok;
  angle_u_t yaw_hundredths;
  angle_s_t pitch_hundredths;
  angle_s_t roll_hundredths;

  modport source (output valid, output frame_ok, output yaw_hundredths,
                  output pitch_hundredths, output roll_hundredths, input ready);
  modport sink   (input valid, input frame_ok, input yaw_hundredths,
                  input pitch_hundredths, input roll_hundredths, output ready);
endinterface

`default_nettype wire

/* sv/sync_frame_attitude_parser.sv */
// Top level of the sync frame attitude parser.
//
//   channel  dir  beat payload                                   handshake
//   rx_i     in   rx_byte                                        valid/ready
//   res_o    out  frame_ok, yaw/pitch/roll_hundredths            valid/ready
//
// One byte is taken per cycle unless a closing byte waits for the result
// register. A byte passes an input register and is processed against the
// frame state in the next cycle; a closing byte loads the frame result.
// Reset clears the position, the last byte, the checksum and the held angles.
// A stalled result blocks only a closing byte and the bytes queued behind it.
`timescale 1ns / 1ps
`default_nettype none

module sync_frame_attitude_parser (
  input wire          clk_i,
  input wire          rst_ni,
  sfap_in_if.sink     rx_i,
  sfap_out_if.source  res_o
);
  import sfap_pkg::*;

  logic        s1_valid_q;
  byte_t       s1_byte_q;
  logic        s1_adv;
  logic        out_free;
  logic        out_load;
  logic        out_valid_q;
  logic        frame_ok_q;
  angle_u_t    held_yaw_q;
  angle_s_t    held_pitch_q;
  angle_s_t    held_roll_q;
  trk_status_t status;
  angle_u_t    new_yaw;
  angle_s_t    new_pitch;
  angle_s_t    new_roll;

  // Stage advance: a closing byte needs room in the result register.
  always_comb begin
    out_free = !out_valid_q || res_o.ready;
    s1_adv   = s1_valid_q && (!status.complete || out_free);
    out_load = s1_adv && status.complete;
  end

  assign rx_i.ready = !s1_valid_q || s1_adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      s1_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      s1_byte_q <= rx_i.rx_byte;
    end
  end

  sfap_frame_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (s1_adv),
    .byte_i   (s1_byte_q),
    .status_o (status),
    .yaw_o    (new_yaw),
    .pitch_o  (new_pitch),
    .roll_o   (new_roll)
  );

  // Result register; the held angles double as its payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      frame_ok_q   <= 1'b0;
      held_yaw_q   <= '0;
      held_pitch_q <= '0;
      held_roll_q  <= '0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
      frame_ok_q  <= status.sum_ok;
      if (status.sum_ok) begin
        held_yaw_q   <= new_yaw;
        held_pitch_q <= new_pitch;
        held_roll_q  <= new_roll;
      end
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.frame_ok         = frame_ok_q;
  assign res_o.yaw_hundredths   = held_yaw_q;
  assign res_o.pitch_hundredths = held_pitch_q;
  assign res_o.roll_hundredths  = held_roll_q;

  // The held attitude moves only when a frame result is loaded.
  a_held_only_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_load |=> $stable(held_yaw_q) && $stable(held_pitch_q) && $stable(held_roll_q))
    else $error("held attitude changed without a frame result");

  // A registered byte that cannot advance is kept.
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_byte_q))
    else $error("registered byte lost while stalled");

  // A loaded result is shown with the checksum verdict of its closing byte.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && (frame_ok_q == $past(status.sum_ok)))
    else $error("frame result not presented as computed");

endmodule

`default_nettype wire

/* sv/sfap_frame_tracker.sv */
// Frame position tracking, header detection, running checksum and payload capture.
`timescale 1ns / 1ps
`default_nettype none

module sfap_frame_tracker (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   adv_i,
  input  sfap_pkg::byte_t       byte_i,
  output sfap_pkg::trk_status_t status_o,
  output sfap_pkg::angle_u_t    yaw_o,
  output sfap_pkg::angle_s_t    pitch_o,
  output sfap_pkg::angle_s_t    roll_o
);
  import sfap_pkg::*;

  pos_t  pos_q, pos_d;
  byte_t prev_q;
  byte_t sum_q, sum_d;
  byte_t payload_q [PayloadLen];

  logic       header;
  logic       complete;
  logic       in_payload;
  logic [2:0] pay_idx;

  // A 0x55 right after a 0xAA restarts the frame; position eleven closes it.
  always_comb begin
    header     = (byte_i == HdrSecond) && (prev_q == HdrFirst);
    complete   = !header && (pos_q == CheckPos);
    in_payload = (pos_q >= PayloadPos) && (pos_q <= PayloadEnd);
    pay_idx    = 3'(pos_q - PayloadPos);
  end

  // Next position and running checksum over positions two to ten.
  always_comb begin
    if (header) begin
      pos_d = AfterHdr;
      sum_d = '0;
    end else if (complete) begin
      pos_d = FrameStart;
      sum_d = '0;
    end else if (pos_q >= SumFirst) begin
      pos_d = pos_q + 4'd1;
      sum_d = sum_q + byte_i;
    end else begin
      pos_d = pos_q + 4'd1;
      sum_d = sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= FrameStart;
      prev_q <= '0;
      sum_q  <= '0;
    end else if (adv_i) begin
      pos_q  <= pos_d;
      prev_q <= byte_i;
      sum_q  <= sum_d;
    end
  end

  // Payload bytes are kept where they land; the header byte may land here too.
  always_ff @(posedge clk_i) begin
    if (adv_i && in_payload) begin
      payload_q[pay_idx] <= byte_i;
    end
  end

  assign status_o = '{complete: complete, sum_ok: (sum_q == byte_i)};

  // Little-endian angle words.
  assign yaw_o   = {payload_q[1], payload_q[0]};
  assign pitch_o = {payload_q[3], payload_q[2]};
  assign roll_o  = {payload_q[5], payload_q[4]};

endmodule

`default_nettype wire
